@@ rtl/smvmm_pkg.sv @@
package smvmm_pkg;

  // Block constants
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_COUNT   = 65536;

  // Port widths
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 38;
  localparam int SD_W     = 23;
  localparam int COUNT_W  = 17;

  // Internal widths
  localparam int SB      = SAMPLE_BITS;
  localparam int CNT_W   = $clog2(MAX_COUNT + 1);
  localparam int SUM_W   = SB + CNT_W;            // signed running sum
  localparam int SQ_W    = 2 * SB + CNT_W - 2;    // running sum of squares
  localparam int ALU_W   = CNT_W + SQ_W;          // n*sumsq and sum^2 both fit
  localparam int NN_W    = 2 * CNT_W;             // n^2, divider remainder
  localparam int SD_FRAC = 16;                    // fraction bits fed to the root
  localparam int X_W     = 2 * SB + 15;           // 65536*var, radicand
  localparam int RT_W    = (X_W + 1) / 2;         // root digits
  localparam int RAD_W   = 2 * RT_W;              // shift reg for dividend/radicand
  localparam int SR_W    = RT_W + 3;              // root partial remainder
  localparam int MQ_W    = SB + 8;                // |mean| quotient bits
  localparam int ITER_MAX = (X_W > SUM_W) ? X_W : SUM_W;
  localparam int IT_W    = $clog2(ITER_MAX + 1);

  localparam logic signed [SB-1:0] SAMPLE_POS_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_NEG_MAX = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic take;   // sample word accepted this cycle
    logic clr;    // statistics captured, start a new set
  } acc_ctl_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sqsum;
    logic signed [SB-1:0]    min;
    logic signed [SB-1:0]    max;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
  } stats_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;  // on subtract: a >= b
  } alu_rsp_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean_q8;
    logic [VAR_W-1:0]           variance_q8;
    logic [SD_W-1:0]            std_dev_q8;
    logic signed [SAMPLE_W-1:0] smallest;
    logic signed [SAMPLE_W-1:0] largest;
    logic [COUNT_W-1:0]         sample_count;
    logic                       overflowed;
  } res_t;

endpackage

@@ rtl/sample_mean_variance_min_max.sv @@
// Running population statistics over sets of signed 16-bit samples. Every
// accepted word adds its sample to a running count, sum, sum of squares,
// minimum and maximum; a word with last set closes the set and yields one
// result word: the floored Q.8 mean, the floored Q.8 population variance,
// the floored Q.8 standard deviation, the minimum, the maximum, the count and
// an overflow flag. Samples past MAX_COUNT in a set are dropped and set the
// flag; a dropped word that carries last still closes the set. Words without
// last are taken one per cycle, back to back. A closing word holds in_stall_o
// high through the closing sequence and any wait for the result register to
// drain: all of the closing math (three shift-add multiplies, a subtract, a
// 24-step and a 47-step restoring divide, a 24-step square root and a negate)
// runs one bit per cycle through a single shared 64-bit add/subtract unit. The
// result sits in an output register, so new samples are taken while it waits.
module sample_mean_variance_min_max (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [smvmm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [smvmm_pkg::MEAN_W-1:0]  mean_q8_o,
  output logic [smvmm_pkg::VAR_W-1:0]          variance_q8_o,
  output logic [smvmm_pkg::SD_W-1:0]           std_dev_q8_o,
  output logic signed [smvmm_pkg::SAMPLE_W-1:0] smallest_o,
  output logic signed [smvmm_pkg::SAMPLE_W-1:0] largest_o,
  output logic [smvmm_pkg::COUNT_W-1:0]        sample_count_o,
  output logic                                 overflowed_o
);
  import smvmm_pkg::*;

  acc_ctl_t acc_ctl;
  stats_t   stats;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  res_t     res;

  // per-sample accumulation, one word per cycle while the input is not stalled
  smvmm_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .sample_i (sample_i),
    .stats_o  (stats)
  );

  // the one adder the closing multiplies, subtract, divides, root and negate run through
  smvmm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // handshake, closing sequence and result register
  smvmm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stats_i     (stats),
    .acc_ctl_o   (acc_ctl),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .res_o       (res)
  );

  assign mean_q8_o      = res.mean_q8;
  assign variance_q8_o  = res.variance_q8;
  assign std_dev_q8_o   = res.std_dev_q8;
  assign smallest_o     = res.smallest;
  assign largest_o      = res.largest;
  assign sample_count_o = res.sample_count;
  assign overflowed_o   = res.overflowed;

endmodule

@@ rtl/smvmm_alu.sv @@
module smvmm_alu (
  input  smvmm_pkg::alu_req_t req_i,
  output smvmm_pkg::alu_rsp_t rsp_o
);
  import smvmm_pkg::*;

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign full = {1'b0, req_i.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req_i.sub};

  assign rsp_o.sum   = full[ALU_W-1:0];
  assign rsp_o.carry = full[ALU_W];

endmodule

@@ rtl/smvmm_acc.sv @@
module smvmm_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smvmm_pkg::acc_ctl_t           ctl_i,
  input  logic [smvmm_pkg::SAMPLE_W-1:0] sample_i,
  output smvmm_pkg::stats_t             stats_o
);
  import smvmm_pkg::*;

  logic signed [SB-1:0]    x;
  logic signed [2*SB-1:0]  xw;
  logic [2*SB-1:0]         sq_c;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sqsum_q;
  logic signed [SB-1:0]    min_q;
  logic signed [SB-1:0]    max_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    ovf_q;
  logic [2*SB-1:0]         sq_q;    // square waiting to be added
  logic                    pend_q;
  logic                    room;

  assign x    = sample_i[SB-1:0];
  assign xw   = {{SB{x[SB-1]}}, x};
  assign sq_c = xw * xw;
  assign room = cnt_q < CNT_W'(MAX_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      min_q   <= SAMPLE_POS_MAX;
      max_q   <= SAMPLE_NEG_MAX;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sq_q    <= '0;
      pend_q  <= 1'b0;
    end else if (ctl_i.clr) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      min_q   <= SAMPLE_POS_MAX;
      max_q   <= SAMPLE_NEG_MAX;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (pend_q) begin
        sqsum_q <= sqsum_q + SQ_W'(sq_q);
      end
      pend_q <= 1'b0;
      if (ctl_i.take) begin
        if (room) begin
          sum_q  <= sum_q + {{(SUM_W-SB){x[SB-1]}}, x};
          if (x < min_q) min_q <= x;
          if (x > max_q) max_q <= x;
          cnt_q  <= cnt_q + CNT_W'(1);
          sq_q   <= sq_c;
          pend_q <= 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign stats_o.sum   = sum_q;
  assign stats_o.sqsum = sqsum_q;
  assign stats_o.min   = min_q;
  assign stats_o.max   = max_q;
  assign stats_o.cnt   = cnt_q;
  assign stats_o.ovf   = ovf_q;

endmodule

@@ rtl/smvmm_seq.sv @@
module smvmm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  smvmm_pkg::stats_t   stats_i,
  output smvmm_pkg::acc_ctl_t acc_ctl_o,
  output smvmm_pkg::alu_req_t alu_req_o,
  input  smvmm_pkg::alu_rsp_t alu_rsp_i,
  output smvmm_pkg::res_t     res_o
);
  import smvmm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETTLE, ST_LOAD, ST_DIV_M, ST_MUL_NQ, ST_MUL_SS,
    ST_SUB_D, ST_MUL_NN, ST_DIV_V, ST_SQRT, ST_NEG_M, ST_DONE
  } state_e;

  state_e                state_q;
  logic [IT_W-1:0]       it_q;
  logic [CNT_W-1:0]      n_q;
  logic                  sneg_q;
  logic [SUM_W-1:0]      smag_q;
  logic [SQ_W-1:0]       sqsum_q;
  logic signed [SB-1:0]  min_q;
  logic signed [SB-1:0]  max_q;
  logic                  ovf_q;
  logic [ALU_W-1:0]      acc_q;
  logic [ALU_W-1:0]      mcand_q;
  logic [SUM_W-1:0]      mplier_q;
  logic [ALU_W-1:0]      p1_q;     // n*sumsq, then d = n*sumsq - sum^2
  logic [NN_W-1:0]       div_q;
  logic [NN_W-1:0]       rem_q;
  logic [RAD_W-1:0]      dvd_q;
  logic [X_W-1:0]        quo_q;
  logic [MQ_W-1:0]       mq_q;
  logic                  rnz_q;
  logic [RT_W-1:0]       root_q;
  logic [SR_W-1:0]       srem_q;
  logic [MEAN_W-1:0]     mean_q;
  logic                  ov_q;
  res_t                  res_q;

  logic [SUM_W-1:0]      smag_c;
  logic [NN_W:0]         dv_t;
  logic [NN_W-1:0]       dv_rem;
  logic [X_W-1:0]        quo_nx;
  logic [SR_W-1:0]       sq_t;
  logic [SR_W-1:0]       sq_trial;
  logic                  last_it;

  assign smag_c   = stats_i.sum[SUM_W-1] ? $unsigned(-stats_i.sum) : $unsigned(stats_i.sum);
  assign dv_t     = {rem_q, dvd_q[RAD_W-1]};
  assign dv_rem   = alu_rsp_i.carry ? alu_rsp_i.sum[NN_W-1:0] : dv_t[NN_W-1:0];
  assign quo_nx   = {quo_q[X_W-2:0], alu_rsp_i.carry};
  assign sq_t     = {srem_q[SR_W-3:0], dvd_q[RAD_W-1 -: 2]};
  assign sq_trial = {{(SR_W-RT_W-2){1'b0}}, root_q, 2'b01};
  assign last_it  = (it_q == IT_W'(1));

  // shared add/sub operand select
  always_comb begin
    alu_req_o = '0;
    unique case (state_q) inside
      ST_MUL_NQ, ST_MUL_SS, ST_MUL_NN: begin
        alu_req_o.a = acc_q;
        alu_req_o.b = mplier_q[0] ? mcand_q : '0;
      end
      ST_SUB_D: begin
        alu_req_o.a   = p1_q;
        alu_req_o.b   = acc_q;
        alu_req_o.sub = 1'b1;
      end
      ST_DIV_M, ST_DIV_V: begin
        alu_req_o.a   = ALU_W'(dv_t);
        alu_req_o.b   = ALU_W'(div_q);
        alu_req_o.sub = 1'b1;
      end
      ST_SQRT: begin
        alu_req_o.a   = ALU_W'(sq_t);
        alu_req_o.b   = ALU_W'(sq_trial);
        alu_req_o.sub = 1'b1;
      end
      ST_NEG_M: begin
        alu_req_o.b   = ALU_W'(mq_q);
        alu_req_o.sub = 1'b1;
      end
      default: alu_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      it_q     <= '0;
      n_q      <= '0;
      sneg_q   <= 1'b0;
      smag_q   <= '0;
      sqsum_q  <= '0;
      min_q    <= '0;
      max_q    <= '0;
      ovf_q    <= 1'b0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      p1_q     <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      dvd_q    <= '0;
      quo_q    <= '0;
      mq_q     <= '0;
      rnz_q    <= 1'b0;
      root_q   <= '0;
      srem_q   <= '0;
      mean_q   <= '0;
      ov_q     <= 1'b0;
      res_q    <= '0;
    end else begin
      // result register: filled from ST_DONE, emptied when taken
      if (state_q == ST_DONE && (!ov_q || !out_stall_i)) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;

      unique case (state_q) inside
        ST_IDLE: begin
          if (in_valid_i && last_i) state_q <= ST_SETTLE;
        end

        // last square add lands this cycle
        ST_SETTLE: state_q <= ST_LOAD;

        ST_LOAD: begin
          n_q     <= stats_i.cnt;
          sneg_q  <= stats_i.sum[SUM_W-1];
          smag_q  <= smag_c;
          sqsum_q <= stats_i.sqsum;
          min_q   <= stats_i.min;
          max_q   <= stats_i.max;
          ovf_q   <= stats_i.ovf;
          // |mean| = floor(256*|sum|/n); high dividend bits preloaded
          div_q   <= NN_W'(stats_i.cnt);
          rem_q   <= NN_W'(smag_c >> SB);
          dvd_q   <= RAD_W'({smag_c[SB-1:0], 8'h00}) << (RAD_W - MQ_W);
          quo_q   <= '0;
          it_q    <= IT_W'(MQ_W);
          state_q <= ST_DIV_M;
        end

        ST_DIV_M, ST_DIV_V: begin
          rem_q <= dv_rem;
          quo_q <= quo_nx;
          if (!last_it) begin
            dvd_q <= dvd_q << 1;
            it_q  <= it_q - IT_W'(1);
          end else if (state_q == ST_DIV_M) begin
            mq_q     <= quo_nx[MQ_W-1:0];
            rnz_q    <= (dv_rem != '0);
            acc_q    <= '0;
            mcand_q  <= ALU_W'(sqsum_q);
            mplier_q <= SUM_W'(n_q);
            it_q     <= IT_W'(CNT_W);
            state_q  <= ST_MUL_NQ;
          end else begin
            // radicand = floor(65536*d/n^2), right aligned
            dvd_q   <= RAD_W'(quo_nx);
            srem_q  <= '0;
            root_q  <= '0;
            it_q    <= IT_W'(RT_W);
            state_q <= ST_SQRT;
          end
        end

        ST_MUL_NQ, ST_MUL_SS, ST_MUL_NN: begin
          if (!last_it) begin
            acc_q    <= alu_rsp_i.sum;
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
            it_q     <= it_q - IT_W'(1);
          end else if (state_q == ST_MUL_NQ) begin
            p1_q     <= alu_rsp_i.sum;
            acc_q    <= '0;
            mcand_q  <= ALU_W'(smag_q);
            mplier_q <= smag_q;
            it_q     <= IT_W'(SUM_W);
            state_q  <= ST_MUL_SS;
          end else if (state_q == ST_MUL_SS) begin
            acc_q   <= alu_rsp_i.sum;
            state_q <= ST_SUB_D;
          end else begin
            // d*65536 / n^2: quotient fits X_W bits, so the top part
            // of the dividend goes straight into the remainder
            div_q   <= alu_rsp_i.sum[NN_W-1:0];
            rem_q   <= NN_W'(p1_q >> (X_W - SD_FRAC));
            dvd_q   <= RAD_W'({p1_q[X_W-SD_FRAC-1:0], {SD_FRAC{1'b0}}}) << (RAD_W - X_W);
            quo_q   <= '0;
            it_q    <= IT_W'(X_W);
            state_q <= ST_DIV_V;
          end
        end

        ST_SUB_D: begin
          p1_q     <= alu_rsp_i.sum;
          acc_q    <= '0;
          mcand_q  <= ALU_W'(n_q);
          mplier_q <= SUM_W'(n_q);
          it_q     <= IT_W'(CNT_W);
          state_q  <= ST_MUL_NN;
        end

        ST_SQRT: begin
          if (alu_rsp_i.carry) begin
            srem_q <= alu_rsp_i.sum[SR_W-1:0];
            root_q <= {root_q[RT_W-2:0], 1'b1};
          end else begin
            srem_q <= sq_t;
            root_q <= {root_q[RT_W-2:0], 1'b0};
          end
          dvd_q <= dvd_q << 2;
          it_q  <= it_q - IT_W'(1);
          if (last_it) state_q <= ST_NEG_M;
        end

        // floor for negative sums: -(q+1) = ~q when a remainder is left
        ST_NEG_M: begin
          if (!sneg_q) mean_q <= MEAN_W'(mq_q);
          else if (rnz_q) mean_q <= ~MEAN_W'(mq_q);
          else mean_q <= alu_rsp_i.sum[MEAN_W-1:0];
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (!ov_q || !out_stall_i) begin
            res_q.mean_q8      <= mean_q;
            res_q.variance_q8  <= VAR_W'(quo_q >> 8);
            res_q.std_dev_q8   <= SD_W'(root_q);
            res_q.smallest     <= SAMPLE_W'(min_q);
            res_q.largest      <= SAMPLE_W'(max_q);
            res_q.sample_count <= COUNT_W'(n_q);
            res_q.overflowed   <= ovf_q;
            state_q            <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign acc_ctl_o.take = (state_q == ST_IDLE) && in_valid_i;
  assign acc_ctl_o.clr  = (state_q == ST_LOAD);
  assign out_valid_o    = ov_q;
  assign res_o          = res_q;

endmodule

@@ rtl/smvmm_chk.sv @@
module smvmm_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [smvmm_pkg::SAMPLE_W-1:0] sample_i,
  input logic                                 last_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [smvmm_pkg::MEAN_W-1:0]  mean_q8_o,
  input logic [smvmm_pkg::VAR_W-1:0]          variance_q8_o,
  input logic [smvmm_pkg::SD_W-1:0]           std_dev_q8_o,
  input logic signed [smvmm_pkg::SAMPLE_W-1:0] smallest_o,
  input logic signed [smvmm_pkg::SAMPLE_W-1:0] largest_o,
  input logic [smvmm_pkg::COUNT_W-1:0]        sample_count_o,
  input logic                                 overflowed_o
);
  import smvmm_pkg::*;

  // a closing word always starts the stalled closing sequence
  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("no stall after closing word");

  // a result covers at least one sample, min not above max
  a_res_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0 && smallest_o <= largest_o)
    else $error("result count or min/max inconsistent");

  // mean lies between 256*min and 256*max
  a_mean_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_q8_o >= $signed({smallest_o, 8'h00})
                 && mean_q8_o <= $signed({largest_o, 8'h00}))
    else $error("mean outside min/max");

  // stalled result word holds its mean, variance, deviation and count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_q8_o)
      && $stable(variance_q8_o) && $stable(std_dev_q8_o) && $stable(sample_count_o))
    else $error("stalled result word changed");

endmodule

bind sample_mean_variance_min_max smvmm_chk u_chk (.*);
